### hdl/multi_stack_linked_pool_assert.svh
// Assertion macros shared by the multi_stack_linked_pool modules.
// Each macro expects clk and arst_n in scope.
`ifndef MULTI_STACK_LINKED_POOL_ASSERT_SVH
`define MULTI_STACK_LINKED_POOL_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MSL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msl assertion failed");

`define MSL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msl assertion failed");

`else

`define MSL_ASSERT_IMP(lbl, ante, cons)

`define MSL_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hdl/msl_pkg.sv
package msl_pkg;

	localparam int DEF_NUM_STACKS  = 10;
	localparam int DEF_POOL_DEPTH  = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int OP_W     = 2;
	localparam int SID_W    = 4;
	localparam int IO_W     = 32;
	localparam int STATUS_W = 2;

	localparam int MAX_OUT = 64;
	localparam int CNT_W   = 6;

	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W      = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_DISPLAY = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SID_W-1:0] sid;
		logic [IO_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

### hdl/msl_front.sv
`include "multi_stack_linked_pool_assert.svh"

module msl_front #(
	parameter int NUM_STACKS = msl_pkg::DEF_NUM_STACKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [msl_pkg::OP_W-1:0]         op,
	input  logic [msl_pkg::SID_W-1:0]        stack_id,
	input  logic signed [msl_pkg::IO_W-1:0]  push_value,
	output msl_pkg::cmd_chan_t               q_out,
	input  logic                             q_pop
);

	msl_pkg::cmd_t                 entry_q [msl_pkg::QUEUE_DEPTH];
	logic                          wr_ptr_q;
	logic                          rd_ptr_q;
	logic [msl_pkg::QCNT_W-1:0]    cnt_q;
	logic                          accept;
	logic                          keep;
	logic                          enq;
	logic                          deq;

	assign full   = (cnt_q == msl_pkg::QCNT_W'(msl_pkg::QUEUE_DEPTH));
	assign accept = push && !full;
	assign keep   = (int'(stack_id) < NUM_STACKS) &&
	                ((op == msl_pkg::OP_PUSH) || (op == msl_pkg::OP_POP) ||
	                 (op == msl_pkg::OP_DISPLAY));
	assign enq    = accept && keep;
	assign deq    = q_pop && (cnt_q != '0);

	assign q_out.valid = (cnt_q != '0);
	assign q_out.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q].op    <= msl_pkg::op_t'(op);
			entry_q[wr_ptr_q].sid   <= stack_id;
			entry_q[wr_ptr_q].value <= $unsigned(push_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`MSL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= msl_pkg::QCNT_W'(msl_pkg::QUEUE_DEPTH))
	`MSL_ASSERT_NXT(a_drop_keeps_cnt, accept && !keep && !deq, cnt_q == $past(cnt_q))
	`MSL_ASSERT_IMP(a_full_stops_enq, full, !enq)

endmodule

### hdl/msl_back.sv
`include "multi_stack_linked_pool_assert.svh"

module msl_back #(
	parameter int NUM_STACKS  = msl_pkg::DEF_NUM_STACKS,
	parameter int POOL_DEPTH  = msl_pkg::DEF_POOL_DEPTH,
	parameter int VALUE_WIDTH = msl_pkg::DEF_VALUE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msl_pkg::cmd_chan_t               q_in,
	output logic                             q_pop,
	output logic                             empty,
	input  logic                             pop,
	output logic [msl_pkg::STATUS_W-1:0]     status,
	output logic signed [msl_pkg::IO_W-1:0]  item_value,
	output logic                             last
);

	localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
	localparam int IDX_W  = $clog2(POOL_DEPTH);
	localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);
	localparam logic [msl_pkg::CNT_W-1:0] CNT_LAST = msl_pkg::CNT_W'(msl_pkg::MAX_OUT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TOP,
		ST_NODE
	} state_t;

	state_t                       state_q;
	msl_pkg::op_t                 op_q;
	logic [SIDX_W-1:0]            sidx_q;
	logic [VALUE_WIDTH-1:0]       val_q;
	logic [PTR_W-1:0]             fc_q;
	logic [PTR_W-1:0]             low_q;
	logic [msl_pkg::CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]             node_q;

	logic                         out_valid_q;
	logic [msl_pkg::STATUS_W-1:0] status_q;
	logic [msl_pkg::IO_W-1:0]     value_q;
	logic                         last_q;

	logic [PTR_W-1:0]             top_mem [NUM_STACKS];
	logic [NUM_STACKS-1:0]        top_valid_q;
	logic [VALUE_WIDTH-1:0]       nval_mem [POOL_DEPTH];
	logic [PTR_W-1:0]             nnxt_mem [POOL_DEPTH];
	logic [IDX_W-1:0]             free_mem [POOL_DEPTH];

	logic [PTR_W-1:0]             top_rd_q;
	logic [IDX_W-1:0]             free_rd_q;
	logic [VALUE_WIDTH-1:0]       nval_rd_q;
	logic [PTR_W-1:0]             nnxt_rd_q;

	logic                         out_free;
	logic [SIDX_W-1:0]            in_sidx;
	logic [PTR_W-1:0]             top_ptr;
	logic                         top_null;
	logic [PTR_W-1:0]             fc_dec;
	logic [IDX_W-1:0]             new_node;
	logic                         pool_empty;
	logic                         nnxt_null;
	logic                         disp_last;

	logic                         top_act;
	logic                         node_act;
	logic                         push_ok;
	logic                         pop_done;
	logic                         node_rd_en;
	logic [IDX_W-1:0]             node_rd_addr;

	assign out_free   = !out_valid_q || pop;
	assign in_sidx    = SIDX_W'(q_in.cmd.sid);
	assign q_pop      = (state_q == ST_IDLE) && q_in.valid;

	assign top_ptr    = top_valid_q[sidx_q] ? top_rd_q : NULL_PTR;
	assign top_null   = (top_ptr == NULL_PTR);
	assign fc_dec     = fc_q - PTR_W'(1);
	assign new_node   = (fc_dec < low_q) ? IDX_W'(fc_dec) : free_rd_q;
	assign pool_empty = (fc_q == '0);
	assign nnxt_null  = (nnxt_rd_q == NULL_PTR);
	assign disp_last  = nnxt_null || (cnt_q == CNT_LAST);

	assign top_act    = (state_q == ST_TOP) && out_free;
	assign node_act   = (state_q == ST_NODE) && out_free;
	assign push_ok    = top_act && (op_q == msl_pkg::OP_PUSH) && !pool_empty;
	assign pop_done   = node_act && (op_q == msl_pkg::OP_POP);
	assign node_rd_en = (top_act && (op_q != msl_pkg::OP_PUSH) && !top_null) ||
	                    (node_act && (op_q == msl_pkg::OP_DISPLAY) && !disp_last);
	assign node_rd_addr = (state_q == ST_TOP) ? IDX_W'(top_ptr) : IDX_W'(nnxt_rd_q);

	assign empty      = !out_valid_q;
	assign status     = status_q;
	assign item_value = $signed(value_q);
	assign last       = last_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			top_rd_q  <= top_mem[in_sidx];
			free_rd_q <= free_mem[IDX_W'(fc_dec)];
		end
		if (push_ok || pop_done) begin
			top_mem[sidx_q] <= push_ok ? PTR_W'(new_node) : nnxt_rd_q;
		end
		if (pop_done) begin
			free_mem[IDX_W'(fc_q)] <= node_q;
		end
	end

	always_ff @(posedge clk) begin
		if (node_rd_en) begin
			nval_rd_q <= nval_mem[node_rd_addr];
			nnxt_rd_q <= nnxt_mem[node_rd_addr];
		end
		if (push_ok) begin
			nval_mem[new_node] <= val_q;
			nnxt_mem[new_node] <= top_ptr;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q   <= q_in.cmd.op;
			sidx_q <= in_sidx;
			val_q  <= VALUE_WIDTH'(q_in.cmd.value);
		end
		if (node_rd_en) begin
			node_q <= node_rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fc_q        <= PTR_W'(POOL_DEPTH);
			low_q       <= PTR_W'(POOL_DEPTH);
			cnt_q       <= '0;
			top_valid_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= msl_pkg::STATUS_OK;
			value_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_TOP;
					end
				end
				ST_TOP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						last_q      <= 1'b1;
						if (op_q == msl_pkg::OP_PUSH) begin
							value_q <= msl_pkg::IO_W'(val_q);
							state_q <= ST_IDLE;
							if (pool_empty) begin
								status_q <= msl_pkg::STATUS_FULL;
							end else begin
								status_q            <= msl_pkg::STATUS_OK;
								fc_q                <= fc_dec;
								top_valid_q[sidx_q] <= 1'b1;
								if (fc_dec < low_q) begin
									low_q <= fc_dec;
								end
							end
						end else if (top_null) begin
							status_q <= msl_pkg::STATUS_EMPTY;
							value_q  <= '0;
							state_q  <= ST_IDLE;
						end else begin
							out_valid_q <= !out_valid_q ? 1'b0 : !pop;
							cnt_q       <= '0;
							state_q     <= ST_NODE;
						end
					end
				end
				ST_NODE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= msl_pkg::STATUS_OK;
						value_q     <= msl_pkg::IO_W'(nval_rd_q);
						if (op_q == msl_pkg::OP_POP) begin
							last_q  <= 1'b1;
							fc_q    <= fc_q + PTR_W'(1);
							state_q <= ST_IDLE;
						end else begin
							last_q <= disp_last;
							cnt_q  <= cnt_q + 1'b1;
							if (disp_last) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MSL_ASSERT_IMP(a_low_below_fc, 1'b1, low_q <= fc_q)
	`MSL_ASSERT_IMP(a_fc_bound, 1'b1, fc_q <= PTR_W'(POOL_DEPTH))
	`MSL_ASSERT_NXT(a_push_takes_node, push_ok, fc_q == $past(fc_dec))
	`MSL_ASSERT_NXT(a_result_held, out_valid_q && !pop, out_valid_q && $stable(value_q))

endmodule

### hdl/multi_stack_linked_pool.sv
// Channel  | handshake            | payload
// ---------+----------------------+-----------------------------
// input    | push / full          | op, stack_id, push_value
// result   | empty / pop          | status, item_value, last
//
// Push finishes at the stack-top read; pop and display then read nodes, one per entry
// shown, through the registered reads of the stack-top and node memories in the back end.
// A two-entry command queue lets the input side run ahead of the back end.
// Inputs with an unknown op or stack id are accepted and dropped.
// arst_n clears all stacks to empty and the node pool to all free.
// The back end holds a result until pop, and stalls while the result register is taken.
module multi_stack_linked_pool #(
	parameter int NUM_STACKS  = msl_pkg::DEF_NUM_STACKS,
	parameter int POOL_DEPTH  = msl_pkg::DEF_POOL_DEPTH,
	parameter int VALUE_WIDTH = msl_pkg::DEF_VALUE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [msl_pkg::OP_W-1:0]         op,
	input  logic [msl_pkg::SID_W-1:0]        stack_id,
	input  logic signed [msl_pkg::IO_W-1:0]  push_value,
	output logic                             empty,
	input  logic                             pop,
	output logic [msl_pkg::STATUS_W-1:0]     status,
	output logic signed [msl_pkg::IO_W-1:0]  item_value,
	output logic                             last
);

	msl_pkg::cmd_chan_t cmd_chan;
	logic               cmd_pop;

	msl_front #(
		.NUM_STACKS(NUM_STACKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.stack_id   (stack_id),
		.push_value (push_value),
		.q_out      (cmd_chan),
		.q_pop      (cmd_pop)
	);

	msl_back #(
		.NUM_STACKS  (NUM_STACKS),
		.POOL_DEPTH  (POOL_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_in       (cmd_chan),
		.q_pop      (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.item_value (item_value),
		.last       (last)
	);

endmodule
